[hw/rtl/calendar_date_normalizer_unit_defines.svh]
`ifndef CALENDAR_DATE_NORMALIZER_UNIT_DEFINES_SVH
`define CALENDAR_DATE_NORMALIZER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CDN_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cdn check failed");

// next-cycle implication, sampled on clk, off during reset
`define CDN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cdn check failed");

`endif

[hw/rtl/cdn_pkg.sv]
package cdn_pkg;

    localparam logic [13:0] MIN_YEAR_RST = 14'd1970;
    localparam logic [13:0] MAX_YEAR_RST = 14'd2038;
    localparam logic [13:0] CUTOVER_RST  = 14'd1752;

    localparam logic [1:0] REG_MIN_YEAR = 2'd0;
    localparam logic [1:0] REG_MAX_YEAR = 2'd1;
    localparam logic [1:0] REG_CUTOVER  = 2'd2;

    // month fold: x = month_in + 263 = (month - 1) + 22 * 12
    localparam logic [9:0]  MONTH_BIAS  = 10'd263;
    localparam logic [15:0] FOLD_BIAS   = 16'd22;
    localparam logic [15:0] YEAR_BIAS   = 16'd400;
    localparam logic [16:0] ZEL_BIAS    = 17'd71;

    // reciprocal constants
    localparam logic [15:0] RECIP_12    = 16'd2731;
    localparam logic [15:0] RECIP_400   = 16'd20972;
    localparam logic [15:0] RECIP_100   = 16'd5243;
    localparam logic [15:0] RECIP_7     = 16'd37450;

    typedef logic [3:0] upc_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_FOLD_MUL,
        OP_FOLD,
        OP_MOD_MUL,
        OP_MOD,
        OP_WALK,
        OP_ZEL_MUL,
        OP_ZEL_SUM,
        OP_WK_MUL,
        OP_OUT
    } op_t;

    typedef enum logic [1:0] {
        CND_NEVER,
        CND_NO_IN,
        CND_WALK,
        CND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        upc_t  jump;
        upc_t  next;
    } uword_t;

    localparam upc_t PC_IDLE     = 4'd0;
    localparam upc_t PC_FOLD_MUL = 4'd1;
    localparam upc_t PC_FOLD     = 4'd2;
    localparam upc_t PC_MOD_MUL  = 4'd3;
    localparam upc_t PC_MOD      = 4'd4;
    localparam upc_t PC_WALK     = 4'd5;
    localparam upc_t PC_ZEL_MUL  = 4'd6;
    localparam upc_t PC_ZEL_SUM  = 4'd7;
    localparam upc_t PC_WK_MUL   = 4'd8;
    localparam upc_t PC_OUT      = 4'd9;

    function automatic uword_t ucode(input upc_t pc);
        uword_t w;
        unique case (pc)
            PC_IDLE:     w = '{OP_LOAD,     CND_NO_IN,    PC_IDLE, PC_FOLD_MUL};
            PC_FOLD_MUL: w = '{OP_FOLD_MUL, CND_NEVER,    PC_IDLE, PC_FOLD};
            PC_FOLD:     w = '{OP_FOLD,     CND_NEVER,    PC_IDLE, PC_MOD_MUL};
            PC_MOD_MUL:  w = '{OP_MOD_MUL,  CND_NEVER,    PC_IDLE, PC_MOD};
            PC_MOD:      w = '{OP_MOD,      CND_NEVER,    PC_IDLE, PC_WALK};
            PC_WALK:     w = '{OP_WALK,     CND_WALK,     PC_WALK, PC_ZEL_MUL};
            PC_ZEL_MUL:  w = '{OP_ZEL_MUL,  CND_NEVER,    PC_IDLE, PC_ZEL_SUM};
            PC_ZEL_SUM:  w = '{OP_ZEL_SUM,  CND_NEVER,    PC_IDLE, PC_WK_MUL};
            PC_WK_MUL:   w = '{OP_WK_MUL,   CND_NEVER,    PC_IDLE, PC_OUT};
            PC_OUT:      w = '{OP_OUT,      CND_OUT_BUSY, PC_OUT,  PC_IDLE};
            default:     w = '{OP_NONE,     CND_NEVER,    PC_IDLE, PC_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [4:0] days_of_month(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        case (m)
            4'd2:                         d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:      d = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            default:                      d = 5'd0;
        endcase
        return d;
    endfunction

    // floor(3 * (m + 1) / 5) for the shifted month 3..14
    function automatic logic [3:0] zel_term(input logic [3:0] m);
        logic [3:0] t;
        case (m)
            4'd3:    t = 4'd2;
            4'd4:    t = 4'd3;
            4'd5:    t = 4'd3;
            4'd6:    t = 4'd4;
            4'd7:    t = 4'd4;
            4'd8:    t = 4'd5;
            4'd9:    t = 4'd6;
            4'd10:   t = 4'd6;
            4'd11:   t = 4'd7;
            4'd12:   t = 4'd7;
            4'd13:   t = 4'd8;
            4'd14:   t = 4'd9;
            default: t = 4'd0;
        endcase
        return t;
    endfunction

endpackage

[hw/rtl/calendar_date_normalizer_unit.sv]
// load, fold multiply, fold, mod multiply, mod, day walk, zeller multiply, zeller sum,
// weekday multiply and output, in turn; the day walk loops while the day is carried over
// month fold, year mod 400, zeller and weekday each use the shared multiplier for two steps
// the next item is taken in idle once the result is in the output register, where it waits
// reset: async active low, sequencer to idle, output invalid, config registers to defaults
module calendar_date_normalizer_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [13:0]        year_in,
    input  logic signed [8:0]  month_in,
    input  logic signed [11:0] day_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [14:0] year_out,
    output logic [3:0]         month_out,
    output logic [4:0]         day_out,
    output logic [2:0]         weekday,
    output logic               leap_flag,
    output logic               year_in_window
);

    logic [13:0] min_year_reg;
    logic [13:0] max_year_reg;
    logic [13:0] cutover_reg;

    cdn_pkg::upc_t   pc_reg;
    cdn_pkg::upc_t   pc_next;
    cdn_pkg::uword_t uw;
    logic            cond_hit;
    logic            out_valid_reg;
    logic            out_busy;
    logic            out_load;

    logic signed [15:0] year_reg;
    logic [3:0]         month_reg;
    logic signed [11:0] day_reg;
    logic [9:0]         x_reg;
    logic [8:0]         ymod_reg;
    logic [29:0]        prod_reg;
    logic [14:0]        sum_reg;

    logic [14:0] mul_a;
    logic [15:0] mul_b;
    logic [30:0] mul_p;

    logic        yr_lt_cut;
    logic        div4;
    logic        century;
    logic        leap_cur;
    logic [4:0]  dim_cur;
    logic [3:0]  month_prev;
    logic [4:0]  dim_prev;
    logic        day_over;
    logic        day_under;
    logic        walk_more;

    logic [5:0]  q_fold;
    logic [9:0]  rem_fold;
    logic [15:0] year_bias;
    logic [5:0]  q_400;
    logic [14:0] rem_400;

    logic               z_early;
    logic signed [15:0] yz;
    logic [3:0]         zm;
    logic [15:0]        yz_neg;
    logic [14:0]        zel_abs;
    logic [7:0]         q_100;
    logic [14:0]        zel_t;
    logic [16:0]        zel_contrib;
    logic [16:0]        zel_s;
    logic [11:0]        q_7;
    logic [14:0]        wk_full;
    logic               in_window;

    // apb config
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_year_reg <= cdn_pkg::MIN_YEAR_RST;
            max_year_reg <= cdn_pkg::MAX_YEAR_RST;
            cutover_reg  <= cdn_pkg::CUTOVER_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                cdn_pkg::REG_MIN_YEAR: min_year_reg <= pwdata[13:0];
                cdn_pkg::REG_MAX_YEAR: max_year_reg <= pwdata[13:0];
                cdn_pkg::REG_CUTOVER:  cutover_reg  <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            cdn_pkg::REG_MIN_YEAR: prdata = {18'd0, min_year_reg};
            cdn_pkg::REG_MAX_YEAR: prdata = {18'd0, max_year_reg};
            cdn_pkg::REG_CUTOVER:  prdata = {18'd0, cutover_reg};
            default:               prdata = 32'd0;
        endcase
    end

    // sequencer
    assign uw       = cdn_pkg::ucode(pc_reg);
    assign in_ready = (pc_reg == cdn_pkg::PC_IDLE);
    assign out_busy = out_valid_reg && !out_ready;
    assign out_load = (uw.op == cdn_pkg::OP_OUT) && !out_busy;

    always_comb
    begin
        case (uw.cond)
            cdn_pkg::CND_NEVER:    cond_hit = 1'b0;
            cdn_pkg::CND_NO_IN:    cond_hit = !in_valid;
            cdn_pkg::CND_WALK:     cond_hit = walk_more;
            cdn_pkg::CND_OUT_BUSY: cond_hit = out_busy;
            default:               cond_hit = 1'b0;
        endcase
        pc_next = cond_hit ? uw.jump : uw.next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= cdn_pkg::PC_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    // leap year and month length of the current year
    assign yr_lt_cut  = year_reg < $signed({2'b00, cutover_reg});
    assign div4       = (year_reg[1:0] == 2'b00);
    assign century    = (ymod_reg == 9'd0) || (ymod_reg == 9'd100) ||
                        (ymod_reg == 9'd200) || (ymod_reg == 9'd300);
    assign leap_cur   = yr_lt_cut ? div4 : ((div4 && !century) || (ymod_reg == 9'd0));
    assign dim_cur    = cdn_pkg::days_of_month(month_reg, leap_cur);
    assign month_prev = (month_reg == 4'd1) ? 4'd12 : month_reg - 4'd1;
    assign dim_prev   = cdn_pkg::days_of_month(month_prev, leap_cur);
    assign day_over   = day_reg > $signed({7'd0, dim_cur});
    assign day_under  = day_reg[11] || (day_reg == 12'sd0);
    assign walk_more  = day_over || day_under;

    // shared multiplier
    always_comb
    begin
        case (uw.op)
            cdn_pkg::OP_FOLD_MUL:
            begin
                mul_a = {5'd0, x_reg};
                mul_b = cdn_pkg::RECIP_12;
            end
            cdn_pkg::OP_MOD_MUL:
            begin
                mul_a = year_bias[14:0];
                mul_b = cdn_pkg::RECIP_400;
            end
            cdn_pkg::OP_ZEL_MUL:
            begin
                mul_a = zel_abs;
                mul_b = cdn_pkg::RECIP_100;
            end
            cdn_pkg::OP_WK_MUL:
            begin
                mul_a = sum_reg;
                mul_b = cdn_pkg::RECIP_7;
            end
            default:
            begin
                mul_a = 15'd0;
                mul_b = 16'd0;
            end
        endcase
    end

    assign mul_p = 31'(mul_a) * 31'(mul_b);

    // month fold
    assign q_fold   = prod_reg[20:15];
    assign rem_fold = x_reg - 10'({q_fold, 3'b000}) - 10'({q_fold, 2'b00});

    // year mod 400
    assign year_bias = year_reg + cdn_pkg::YEAR_BIAS;
    assign q_400     = prod_reg[28:23];
    assign rem_400   = year_bias[14:0] - 15'({q_400, 8'd0}) - 15'({q_400, 7'd0})
                       - 15'({q_400, 4'd0});

    // zeller
    assign z_early     = (month_reg == 4'd1) || (month_reg == 4'd2);
    assign yz          = z_early ? year_reg - 16'sd1 : year_reg;
    assign zm          = z_early ? month_reg + 4'd12 : month_reg;
    assign yz_neg      = 16'd0 - yz;
    assign zel_abs     = yz[15] ? yz_neg[14:0] : yz[14:0];
    assign q_100       = prod_reg[26:19];
    assign zel_t       = {2'b00, zel_abs[14:2]} - {7'd0, q_100} + {9'd0, q_100[7:2]};
    assign zel_contrib = yz[15] ? 17'd0 - {2'b00, zel_t} : {2'b00, zel_t};
    assign zel_s       = {{5{day_reg[11]}}, day_reg} + {12'd0, zm, 1'b0}
                         + {13'd0, cdn_pkg::zel_term(zm)} + {yz[15], yz}
                         + zel_contrib + cdn_pkg::ZEL_BIAS;
    assign q_7         = prod_reg[29:18];
    assign wk_full     = sum_reg - (15'({q_7, 3'b000}) - 15'(q_7));

    assign in_window = (year_reg >= $signed({2'b00, min_year_reg})) &&
                       (year_reg <= $signed({2'b00, max_year_reg}));

    // datapath
    always_ff @(posedge clk)
    begin
        case (uw.op) inside
            cdn_pkg::OP_LOAD:
            begin
                if (in_valid)
                begin
                    year_reg <= {2'b00, year_in};
                    x_reg    <= {month_in[8], month_in} + cdn_pkg::MONTH_BIAS;
                    day_reg  <= day_in;
                end
            end
            cdn_pkg::OP_FOLD_MUL, cdn_pkg::OP_MOD_MUL, cdn_pkg::OP_ZEL_MUL,
            cdn_pkg::OP_WK_MUL:
            begin
                prod_reg <= mul_p[29:0];
            end
            cdn_pkg::OP_FOLD:
            begin
                year_reg  <= year_reg + {10'd0, q_fold} - cdn_pkg::FOLD_BIAS;
                month_reg <= rem_fold[3:0] + 4'd1;
            end
            cdn_pkg::OP_MOD:
            begin
                ymod_reg <= rem_400[8:0];
            end
            cdn_pkg::OP_WALK:
            begin
                if (day_over)
                begin
                    day_reg <= day_reg - $signed({7'd0, dim_cur});
                    if (month_reg == 4'd12)
                    begin
                        month_reg <= 4'd1;
                        year_reg  <= year_reg + 16'sd1;
                        ymod_reg  <= (ymod_reg == 9'd399) ? 9'd0 : ymod_reg + 9'd1;
                    end
                    else
                    begin
                        month_reg <= month_reg + 4'd1;
                    end
                end
                else if (day_under)
                begin
                    day_reg   <= day_reg + $signed({7'd0, dim_prev});
                    month_reg <= month_prev;
                    if (month_reg == 4'd1)
                    begin
                        year_reg <= year_reg - 16'sd1;
                        ymod_reg <= (ymod_reg == 9'd0) ? 9'd399 : ymod_reg - 9'd1;
                    end
                end
            end
            cdn_pkg::OP_ZEL_SUM:
            begin
                sum_reg <= zel_s[14:0];
            end
            cdn_pkg::OP_OUT:
            begin
                if (!out_busy)
                begin
                    year_out       <= year_reg[14:0];
                    month_out      <= month_reg;
                    day_out        <= day_reg[4:0];
                    weekday        <= wk_full[2:0];
                    leap_flag      <= leap_cur;
                    year_in_window <= in_window;
                end
            end
            default: ;
        endcase
    end

endmodule

[hw/rtl/cdn_checker.sv]
`include "calendar_date_normalizer_unit_defines.svh"

module cdn_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [14:0] year_out,
    input logic [3:0]         month_out,
    input logic [4:0]         day_out,
    input logic [2:0]         weekday,
    input logic               leap_flag
);

    // result fields within their calendar ranges
    `CDN_ASSERT_NOW(a_out_range, out_valid, (month_out >= 4'd1) && (month_out <= 4'd12) && (day_out >= 5'd1) && (day_out <= 5'd31) && (weekday <= 3'd6))

    // the sequencer is busy right after taking a beat
    `CDN_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready)

    // a new result only comes out of a busy sequencer
    `CDN_ASSERT_NOW(a_out_from_work, $rose(out_valid), $past(!in_ready))

    // leap years are multiples of four under both rules
    `CDN_ASSERT_NOW(a_leap_div4, out_valid && leap_flag, year_out[1:0] == 2'b00)

    // february 29 only in a leap year
    `CDN_ASSERT_NOW(a_feb29_leap, out_valid && (month_out == 4'd2) && (day_out == 5'd29), leap_flag)

endmodule

bind calendar_date_normalizer_unit cdn_checker u_cdn_checker (.*);

[tb/calendar_date_normalizer_unit_tb.sv]
`timescale 1ns / 100ps

module calendar_date_normalizer_unit_tb;

    typedef struct packed {
        logic [13:0] year;
        logic [8:0]  month;
        logic [11:0] day;
    } raw_date_t;

    typedef struct packed {
        logic [14:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  wday;
        logic        leap;
        logic        in_window;
    } norm_date_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SLOTTED,
        RX_STARVED
    } rx_mode_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [13:0]        year_in = '0;
    logic signed [8:0]  month_in = '0;
    logic signed [11:0] day_in = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [14:0] year_out;
    logic [3:0]         month_out;
    logic [4:0]         day_out;
    logic [2:0]         weekday;
    logic               leap_flag;
    logic               year_in_window;

    raw_date_t  raw_dates[$];
    norm_date_t normalized_dates[$];

    int lo_year_cfg = 1970;
    int hi_year_cfg = 2038;
    int cutover_cfg = 1752;

    int mismatches = 0;
    int dates_taken = 0;
    int results_checked = 0;
    int settings_used = 1;

    logic      in_beat = 1'b0;
    int        gap_left = 0;
    int        burst_left = 8;
    raw_date_t next_date;
    rx_mode_t  rx_mode = RX_OPEN;
    int        rx_hold = 0;

    calendar_date_normalizer_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .year_in        (year_in),
        .month_in       (month_in),
        .day_in         (day_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .year_out       (year_out),
        .month_out      (month_out),
        .day_out        (day_out),
        .weekday        (weekday),
        .leap_flag      (leap_flag),
        .year_in_window (year_in_window)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic bit leap_year(input int y);
        if (y < cutover_cfg)
            return y[1:0] == 2'b00;
        return (y[1:0] == 2'b00 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int month_length(input int y, input int m);
        case (m)
            2:                       return leap_year(y) ? 29 : 28;
            4, 6, 9, 11:             return 30;
            default:                 return 31;
        endcase
    endfunction

    function automatic int zeller_weekday(input int y, input int m, input int d);
        int w;
        if (m <= 2)
        begin
            m = m + 12;
            y = y - 1;
        end
        w = (d + 2 * m + 3 * (m + 1) / 5 + y + y / 4 - y / 100 + y / 400 + 1) % 7;
        if (w < 0)
            w = w + 7;
        return w;
    endfunction

    function automatic norm_date_t normalize_date(input logic [13:0] y_in,
                                                  input logic signed [8:0] m_in,
                                                  input logic signed [11:0] d_in);
        int yr;
        int mo;
        int dy;
        int q;
        int r;
        int dim;
        bit settled;
        norm_date_t res;
        yr = int'(y_in);
        dy = int'(d_in);
        q = (int'(m_in) - 1) / 12;
        r = (int'(m_in) - 1) % 12;
        if (r < 0)
        begin
            r = r + 12;
            q = q - 1;
        end
        yr = yr + q;
        mo = r + 1;
        settled = 1'b0;
        while (!settled)
        begin
            dim = month_length(yr, mo);
            if (dy > dim)
            begin
                dy = dy - dim;
                mo = mo + 1;
                if (mo > 12)
                begin
                    mo = 1;
                    yr = yr + 1;
                end
            end
            else if (dy < 1)
            begin
                mo = mo - 1;
                if (mo < 1)
                begin
                    mo = 12;
                    yr = yr - 1;
                end
                dy = dy + month_length(yr, mo);
            end
            else
                settled = 1'b1;
        end
        res.year = yr[14:0];
        res.month = mo[3:0];
        res.day = dy[4:0];
        res.wday = 3'(zeller_weekday(yr, mo, dy));
        res.leap = leap_year(yr);
        res.in_window = (yr >= lo_year_cfg) && (yr <= hi_year_cfg);
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // input beats feed the predictor, result beats are checked in order
    always @(posedge clk)
    begin
        norm_date_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (normalized_dates.size() == 0)
                    flag_mismatch("result beat with nothing pending, year", int'(year_out), 0);
                else
                begin
                    want = normalized_dates.pop_front();
                    results_checked++;
                    if (year_out !== $signed(want.year))
                        flag_mismatch("year_out", int'(year_out), int'($signed(want.year)));
                    if (month_out !== want.month)
                        flag_mismatch("month_out", month_out, want.month);
                    if (day_out !== want.day)
                        flag_mismatch("day_out", day_out, want.day);
                    if (weekday !== want.wday)
                        flag_mismatch("weekday", weekday, want.wday);
                    if (leap_flag !== want.leap)
                        flag_mismatch("leap_flag", leap_flag, want.leap);
                    if (year_in_window !== want.in_window)
                        flag_mismatch("year_in_window", year_in_window, want.in_window);
                end
            end
            if (in_valid && in_ready)
            begin
                normalized_dates.push_back(normalize_date(year_in, month_in, day_in));
                dates_taken++;
            end
            in_beat <= in_valid && in_ready;
        end
    end

    // sender: bursts of beats separated by random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_beat))
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left = gap_left - 1;
            end
            else if (raw_dates.size() != 0)
            begin
                next_date = raw_dates.pop_front();
                year_in <= next_date.year;
                month_in <= next_date.month;
                day_in <= next_date.day;
                in_valid <= 1'b1;
                burst_left = burst_left - 1;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: stall pattern switches after a random hold time
    always @(negedge clk)
    begin
        if (rx_hold == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_hold = $urandom_range(50, 300);
        end
        rx_hold = rx_hold - 1;
        case (rx_mode)
            RX_OPEN:    out_ready <= 1'b1;
            RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
            RX_SLOTTED: out_ready <= (rx_hold % 16) < 10;
            default:    out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic add_date(input int y, input int m, input int d);
        raw_date_t item;
        item.year = y[13:0];
        item.month = m[8:0];
        item.day = d[11:0];
        raw_dates.push_back(item);
    endtask

    task automatic apb_write(input logic [1:0] idx, input int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            cdn_pkg::REG_MIN_YEAR: lo_year_cfg = value & 16'h3fff;
            cdn_pkg::REG_MAX_YEAR: hi_year_cfg = value & 16'h3fff;
            cdn_pkg::REG_CUTOVER:  cutover_cfg = value & 16'h3fff;
            default:               ;
        endcase
    endtask

    task automatic set_calendar(input int lo, input int hi, input int cut);
        apb_write(cdn_pkg::REG_MIN_YEAR, lo);
        apb_write(cdn_pkg::REG_MAX_YEAR, hi);
        apb_write(cdn_pkg::REG_CUTOVER, cut);
        settings_used++;
    endtask

    task automatic wait_idle();
        while (raw_dates.size() != 0 || in_valid || normalized_dates.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic queue_random_dates(input int count);
        int y;
        int m;
        int d;
        for (int i = 0; i < count; i++)
        begin
            y = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 9999);
            case ($urandom_range(0, 3))
                0:
                begin
                    m = int'($urandom_range(0, 511)) - 256;
                    d = int'($urandom_range(0, 4095)) - 2048;
                end
                1:
                begin
                    m = int'($urandom_range(0, 30)) - 8;
                    d = int'($urandom_range(0, 100)) - 30;
                end
                default:
                begin
                    m = $urandom_range(1, 12);
                    d = $urandom_range(1, 31);
                end
            endcase
            add_date(y, m, d);
        end
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        add_date(2024, 2, 29);
        add_date(1900, 2, 29);
        add_date(2000, 2, 29);
        add_date(1700, 2, 29);
        add_date(2100, 3, 0);
        add_date(2023, 0, 1);
        add_date(2023, 12, 31);
        add_date(2023, 24, 31);
        add_date(2023, -12, 15);
        add_date(2023, 13, 0);
        add_date(0, 1, 1);
        add_date(1, 1, -1);
        add_date(0, -255, -2047);
        add_date(0, -256, -2048);
        add_date(9999, 255, 2047);
        add_date(16383, 255, 2047);
        add_date(16383, 12, 31);
        add_date(2038, 12, 31);
        add_date(2039, 1, 1);
        add_date(1969, 12, 31);
        add_date(1970, 1, 1);
        add_date(2024, 3, -1000);
        add_date(2024, 1, 2047);
        add_date(2000, 1, 0);
        wait_idle();

        // gregorian from year 0 on, window 0 to 9999
        set_calendar(0, 9999, 0);
        queue_random_dates(150);
        wait_idle();

        // julian below year 9999, window inverted
        set_calendar(9999, 0, 9999);
        queue_random_dates(150);
        wait_idle();

        set_calendar($urandom_range(0, 9999), $urandom_range(0, 9999), $urandom_range(0, 9999));
        queue_random_dates(150);
        wait_idle();

        set_calendar(1970, 2038, 1752);
        queue_random_dates(150);
        wait_idle();

        $display("normalized %0d dates under %0d calendar settings", dates_taken, settings_used);
        $display("%0d results compared field by field", results_checked);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
